### hdl/rmth_pkg.sv
// rmth_pkg: shared constants, types and compare helper for the running median block
// no dependencies
package rmth_pkg;

	localparam int HALF_CAPACITY = 512;
	localparam int VALUE_WIDTH   = 32;
	localparam int ADDR_W        = $clog2(HALF_CAPACITY);
	localparam int CNT_W         = ADDR_W + 1;
	localparam int IDX_W         = ADDR_W + 2;
	localparam int MED_W         = VALUE_WIDTH + 1;
	localparam int OCNT_W        = 11;
	localparam int TDATA_W       = ((MED_W + OCNT_W + 7) / 8) * 8;

	typedef logic [VALUE_WIDTH-1:0] value_t;

	typedef enum logic {
		OP_PUSH,
		OP_REPLACE
	} heap_op_t;

	typedef enum logic [2:0] {
		H_IDLE,
		H_UP_RD,
		H_UP_CMP,
		H_WR_FINAL,
		H_DN_RD,
		H_DN_CMP
	} heap_state_t;

	typedef enum logic {
		ST_IDLE,
		ST_WAIT
	} top_state_t;

	typedef struct packed {
		logic             valid;
		heap_op_t         op;
		value_t           value;
		logic [CNT_W-1:0] count;
	} heap_cmd_t;

	typedef struct packed {
		logic   busy;
		value_t top;
	} heap_stat_t;

	// true when a belongs nearer the root than b
	function automatic logic ahead(input value_t a, input value_t b, input logic is_max);
		if (is_max) begin
			return $signed(b) < $signed(a);
		end
		return $signed(a) < $signed(b);
	endfunction

endpackage

### hdl/rmth_ram.sv
// rmth_ram: generic ram, one write port and two registered read ports
// no dependencies
module rmth_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] ra_addr,
	output logic [WIDTH-1:0]         ra_data,
	input  logic [$clog2(DEPTH)-1:0] rb_addr,
	output logic [WIDTH-1:0]         rb_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		ra_data <= mem[ra_addr];
		rb_data <= mem[rb_addr];
	end

endmodule

### hdl/rmth_heap.sv
// rmth_heap: one binary heap in a ram, push by sift-up and replace-top by sift-down
// depends on rmth_pkg and rmth_ram
module rmth_heap (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               is_max,
	input  rmth_pkg::heap_cmd_t  cmd,
	output rmth_pkg::heap_stat_t stat
);
	import rmth_pkg::*;

	heap_state_t      state_q, state_d;
	logic [ADDR_W-1:0] pos_q, pos_d;
	logic [ADDR_W-1:0] par_q, par_d;
	logic [IDX_W-1:0]  lidx_q, lidx_d;
	logic [CNT_W-1:0]  n_q, n_d;
	value_t            val_q, val_d;
	value_t            top_q;

	logic              we;
	logic [ADDR_W-1:0] waddr;
	value_t            wdata;
	logic [ADDR_W-1:0] ra_addr, rb_addr;
	value_t            ra_data, rb_data;

	logic [IDX_W-1:0]  ridx;
	logic              take_l, take_r;
	value_t            best_v;

	rmth_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(HALF_CAPACITY)) u_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.ra_addr (ra_addr),
		.ra_data (ra_data),
		.rb_addr (rb_addr),
		.rb_data (rb_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q  <= pos_d;
		par_q  <= par_d;
		lidx_q <= lidx_d;
		n_q    <= n_d;
		val_q  <= val_d;
		if (we && waddr == '0) begin
			top_q <= wdata;
		end
	end

	assign ridx   = lidx_q + IDX_W'(1);
	assign take_l = (lidx_q < IDX_W'(n_q)) && ahead(ra_data, val_q, is_max);
	assign best_v = take_l ? ra_data : val_q;
	assign take_r = (ridx < IDX_W'(n_q)) && ahead(rb_data, best_v, is_max);

	always_comb begin
		state_d = state_q;
		pos_d   = pos_q;
		par_d   = par_q;
		lidx_d  = lidx_q;
		n_d     = n_q;
		val_d   = val_q;
		we      = 1'b0;
		waddr   = pos_q;
		wdata   = val_q;
		ra_addr = par_q;
		rb_addr = par_q;
		unique case (state_q)
			H_IDLE: begin
				if (cmd.valid) begin
					val_d = cmd.value;
					n_d   = cmd.count;
					if (cmd.op == OP_PUSH) begin
						pos_d = cmd.count[ADDR_W-1:0];
						if (cmd.count == '0) begin
							we    = 1'b1;
							waddr = '0;
							wdata = cmd.value;
						end else begin
							state_d = H_UP_RD;
						end
					end else begin
						pos_d   = '0;
						state_d = H_DN_RD;
					end
				end
			end
			H_UP_RD: begin
				par_d   = (pos_q - ADDR_W'(1)) >> 1;
				ra_addr = par_d;
				state_d = H_UP_CMP;
			end
			H_UP_CMP: begin
				we = 1'b1;
				if (ahead(val_q, ra_data, is_max)) begin
					// parent moves down into the hole
					wdata   = ra_data;
					pos_d   = par_q;
					state_d = (par_q == '0) ? H_WR_FINAL : H_UP_RD;
				end else begin
					state_d = H_IDLE;
				end
			end
			H_WR_FINAL: begin
				we      = 1'b1;
				state_d = H_IDLE;
			end
			H_DN_RD: begin
				lidx_d  = {1'b0, pos_q, 1'b1};
				ra_addr = lidx_d[ADDR_W-1:0];
				rb_addr = ADDR_W'(lidx_d + IDX_W'(1));
				state_d = H_DN_CMP;
			end
			H_DN_CMP: begin
				we = 1'b1;
				if (take_r) begin
					wdata   = rb_data;
					pos_d   = ridx[ADDR_W-1:0];
					state_d = H_DN_RD;
				end else if (take_l) begin
					wdata   = ra_data;
					pos_d   = lidx_q[ADDR_W-1:0];
					state_d = H_DN_RD;
				end else begin
					state_d = H_IDLE;
				end
			end
			default: state_d = H_IDLE;
		endcase
	end

	assign stat.busy = (state_q != H_IDLE);
	assign stat.top  = top_q;

endmodule

### hdl/running_median_two_heaps.sv
// running_median_two_heaps: top level, balances a max-heap and a min-heap and reports the median
// depends on rmth_pkg, rmth_heap (and through it rmth_ram)
//
// Each transfer on the input adds one signed value and yields one result: twice the median of all
// values held (exact, one implied fractional bit), the count held, and a refused flag that is set
// when the store holds 2*HALF_CAPACITY-1 values (the value is dropped and the previous median is
// repeated). The next value is accepted only once both heaps have finished their sift and the
// output register is free. The lower and upper heaps each sit in their own ram and sift in
// parallel, one tree level at a time (ram read, then compare and write). The heap roots are
// mirrored in registers, so the routing decision and the median need no ram read. A finished
// result waits in an output register while the next item is accepted. The rams need no
// clearing after reset.
module running_median_two_heaps (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [rmth_pkg::VALUE_WIDTH-1:0] s_tdata,  // value
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [rmth_pkg::TDATA_W-1:0] m_tdata,  // median_doubled, element_count, zero fill
	output logic                         m_tuser   // refused
);
	import rmth_pkg::*;

	top_state_t       state_q, state_d;
	logic [CNT_W-1:0] lower_count_q, upper_count_q;
	logic             refused_q;
	logic             m_tvalid_q;
	logic [TDATA_W-1:0] m_tdata_q;
	logic             m_tuser_q;

	heap_cmd_t  lower_cmd, upper_cmd;
	heap_stat_t lower_stat, upper_stat;

	logic   in_xfer, full, v_above_l, v_above_u;
	value_t v;
	logic   out_free, finish;
	logic signed [MED_W-1:0] median;
	logic [OCNT_W-1:0] total;

	assign v         = s_tdata;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_xfer   = s_tvalid && s_tready;
	// lower can only reach full size while upper trails by one
	assign full      = (lower_count_q >= CNT_W'(HALF_CAPACITY))
	                || (upper_count_q >= CNT_W'(HALF_CAPACITY));
	assign v_above_l = $signed(lower_stat.top) < $signed(v);
	assign v_above_u = $signed(upper_stat.top) < $signed(v);

	// route the new value; a moved root goes to the other heap in parallel
	always_comb begin
		lower_cmd       = '0;
		upper_cmd       = '0;
		lower_cmd.count = lower_count_q;
		upper_cmd.count = upper_count_q;
		lower_cmd.op    = OP_PUSH;
		upper_cmd.op    = OP_PUSH;
		lower_cmd.value = v;
		upper_cmd.value = v;
		if (in_xfer && !full) begin
			if (lower_count_q == upper_count_q) begin
				lower_cmd.valid = 1'b1;
				if (lower_count_q != '0 && upper_count_q != '0 && v_above_l && v_above_u) begin
					// upper root drops into lower, value replaces it
					lower_cmd.value = upper_stat.top;
					upper_cmd.valid = 1'b1;
					upper_cmd.op    = OP_REPLACE;
				end
			end else begin
				upper_cmd.valid = 1'b1;
				if (!v_above_l) begin
					upper_cmd.value = lower_stat.top;
					lower_cmd.valid = 1'b1;
					lower_cmd.op    = OP_REPLACE;
				end
			end
		end
	end

	rmth_heap u_lower (
		.clk    (clk),
		.arst_n (arst_n),
		.is_max (1'b1),
		.cmd    (lower_cmd),
		.stat   (lower_stat)
	);

	rmth_heap u_upper (
		.clk    (clk),
		.arst_n (arst_n),
		.is_max (1'b0),
		.cmd    (upper_cmd),
		.stat   (upper_stat)
	);

	assign out_free = !m_tvalid_q || m_tready;
	assign finish   = (state_q == ST_WAIT) && !lower_stat.busy && !upper_stat.busy && out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_xfer) state_d = ST_WAIT;
			ST_WAIT: if (finish)  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// median from the mirrored roots, at full width
	always_comb begin
		if (lower_count_q == '0) begin
			median = '0;
		end else if (lower_count_q == upper_count_q) begin
			median = $signed({lower_stat.top[VALUE_WIDTH-1], lower_stat.top})
			       + $signed({upper_stat.top[VALUE_WIDTH-1], upper_stat.top});
		end else begin
			median = $signed({lower_stat.top, 1'b0});
		end
	end
	assign total = OCNT_W'(lower_count_q) + OCNT_W'(upper_count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			lower_count_q <= '0;
			upper_count_q <= '0;
			m_tvalid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (lower_cmd.valid && lower_cmd.op == OP_PUSH) begin
				lower_count_q <= lower_count_q + CNT_W'(1);
			end
			if (upper_cmd.valid && upper_cmd.op == OP_PUSH) begin
				upper_count_q <= upper_count_q + CNT_W'(1);
			end
			if (finish) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			refused_q <= full;
		end
		if (finish) begin
			m_tdata_q <= TDATA_W'({total, median});
			m_tuser_q <= refused_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// halves stay balanced with the extra value in the lower heap
	assert property (@(posedge clk) disable iff (!arst_n)
		lower_count_q == upper_count_q || lower_count_q == upper_count_q + CNT_W'(1))
		else $error("heap counts out of balance");

	// no heap grows past its capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		lower_count_q <= CNT_W'(HALF_CAPACITY) && upper_count_q <= CNT_W'(HALF_CAPACITY))
		else $error("heap count beyond capacity");

	// heaps are quiet whenever a new value may enter
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !lower_stat.busy && !upper_stat.busy)
		else $error("heap busy while idle");

	// a refused item leaves the counts untouched
	assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && full |=> $stable(lower_count_q) && $stable(upper_count_q))
		else $error("refused value changed counts");

endmodule

### tb/tb_running_median_two_heaps.sv
// tb_running_median_two_heaps: self-checking testbench for the two-heap running median block
// depends on rmth_pkg and running_median_two_heaps
module tb_running_median_two_heaps;
	import rmth_pkg::*;

	localparam int IDLE_LIMIT = 20000;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [VALUE_WIDTH-1:0] s_tdata;   // value
	logic                   m_tvalid;
	logic                   m_tready;
	logic [TDATA_W-1:0]     m_tdata;   // median_doubled, element_count, zero fill
	logic                   m_tuser;   // refused

	typedef struct packed {
		logic [MED_W-1:0]  median_doubled;
		logic [OCNT_W-1:0] element_count;
		logic              refused;
	} median_result_t;

	// predictor state: sorted copy of every value held
	logic signed [VALUE_WIDTH-1:0] held_sorted[$];
	median_result_t medians_pending[$];

	int  errors;
	int  idle_cycles;
	bit  hold_off_req;
	int  hold_off_len;
	bit  sink_long_gaps;

	running_median_two_heaps u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// median of a sorted set equals the heap answer: lower half gets the extra element
	// the store is full at one value short of both halves, lower at capacity
	function automatic median_result_t predict_median(input logic signed [VALUE_WIDTH-1:0] v);
		median_result_t r;
		int n;
		int k;
		logic signed [MED_W-1:0] a;
		logic signed [MED_W-1:0] b;
		n = held_sorted.size();
		r.refused = (n >= 2 * HALF_CAPACITY - 1);
		if (!r.refused) begin
			k = 0;
			while (k < n && held_sorted[k] < v) k++;
			held_sorted.insert(k, v);
			n++;
		end
		if (n == 0) begin
			r.median_doubled = '0;
		end else if (n % 2 == 1) begin
			a = held_sorted[n/2];
			r.median_doubled = a + a;
		end else begin
			a = held_sorted[n/2 - 1];
			b = held_sorted[n/2];
			r.median_doubled = a + b;
		end
		r.element_count = n[OCNT_W-1:0];
		return r;
	endfunction

	task automatic pause_random(input bit long_ok);
		int gap;
		if (long_ok && $urandom_range(0, 19) == 0) gap = $urandom_range(20, 80);
		else if ($urandom_range(0, 2) == 0) gap = $urandom_range(1, 3);
		else gap = 0;
		repeat (gap) @(negedge clk);
	endtask

	// offer one value and wait for the transfer
	task automatic send_value(input logic [VALUE_WIDTH-1:0] v, input bit gaps);
		if (gaps) pause_random(1'b1);
		s_tvalid = 1'b1;
		s_tdata  = v;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		medians_pending.insert(medians_pending.size(), predict_median(v));
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic wait_drained();
		while (medians_pending.size() != 0) @(negedge clk);
	endtask

	function automatic logic [VALUE_WIDTH-1:0] random_value();
		case ($urandom_range(0, 5))
			0: return {1'b0, {(VALUE_WIDTH-1){1'b1}}};
			1: return {1'b1, {(VALUE_WIDTH-1){1'b0}}};
			2: return $urandom_range(0, 20) - 10;
			default: return $urandom;
		endcase
	endfunction

	// extremes, overflow of the doubled sum, duplicates, empty-start
	task automatic test_directed();
		logic [VALUE_WIDTH-1:0] dir[$];
		dir = '{32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h00000000, 32'hffffffff, 32'h00000001, 32'h7fffffff, 32'h55555555,
			32'haaaaaaaa, 32'h00000005, 32'h00000005, 32'h00000005, 32'hfffffffe,
			32'h12345678, 32'hedcba987, 32'h00000000};
		foreach (dir[i]) send_value(dir[i], 1'b0);
		wait_drained();
	endtask

	// random content with gaps on both sides
	task automatic test_random(input int n);
		repeat (n) send_value(random_value(), 1'b1);
	endtask

	// sink holds off long while the source keeps offering
	task automatic test_backpressure();
		hold_off_len = 300;
		hold_off_req = 1'b1;
		repeat (20) send_value(random_value(), 1'b0);
		wait_drained();
	endtask

	// fill to capacity, then values are refused and median repeats
	task automatic test_fill_and_refuse();
		sink_long_gaps = 1'b0;
		while (held_sorted.size() < 2 * HALF_CAPACITY - 1) send_value(random_value(), 1'b0);
		repeat (527) send_value(random_value(), 1'b1);
		sink_long_gaps = 1'b1;
		wait_drained();
	endtask

	// sink: random ready with occasional long stalls and a requested hold-off
	initial begin
		m_tready = 1'b0;
		sink_long_gaps = 1'b1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				m_tready = 1'b0;
				repeat (hold_off_len) @(negedge clk);
				hold_off_req = 1'b0;
			end
			if (m_tready && $urandom_range(0, 3) == 0) begin
				m_tready = 1'b0;
				pause_random(sink_long_gaps);
			end
			m_tready = ($urandom_range(0, 5) != 0);
		end
	end

	// result checker
	always @(posedge clk) begin
		median_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (medians_pending.size() == 0) begin
				$error("unexpected result transfer: median %0h", m_tdata[MED_W-1:0]);
				errors++;
			end else begin
				want = medians_pending.pop_front();
				if (m_tdata[MED_W-1:0] !== want.median_doubled) begin
					$error("median_doubled expected %0h actual %0h",
						want.median_doubled, m_tdata[MED_W-1:0]);
					errors++;
				end
				if (m_tdata[MED_W +: OCNT_W] !== want.element_count) begin
					$error("element_count expected %0d actual %0d",
						want.element_count, m_tdata[MED_W +: OCNT_W]);
					errors++;
				end
				if (m_tuser !== want.refused) begin
					$error("refused expected %0b actual %0b", want.refused, m_tuser);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		errors = 0;
		idle_cycles = 0;
		hold_off_req = 1'b0;
		hold_off_len = 0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		arst_n = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(400);
		test_backpressure();
		test_random(80);
		wait_drained();
		test_fill_and_refuse();
		wait_drained();
		repeat (50) @(negedge clk);
		if (errors == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

endmodule
